[rtl/uld_pkg.sv]
// ----------------------------------------------------------------------------
// uld_pkg
// Shared types, character codes and helper functions for the URI list
// percent decoder.
// ----------------------------------------------------------------------------
package uld_pkg;

  // One word on the input channel
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } in_item_t;

  // One word on the result channel
  typedef struct packed {
    logic [7:0] path_byte;
    logic       path_last;
  } out_item_t;

  // Symbol passed from the line front end to the escape decoder
  typedef struct packed {
    logic       eol;
    logic [7:0] data;
  } sym_t;

  // Escape decoder phase
  typedef enum logic [1:0] {
    PCT_IDLE  = 2'd0,
    PCT_ONE   = 2'd1,
    PCT_TWO   = 2'd2,
    PCT_FIRST = 2'd3
  } pct_phase_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam int unsigned PREFIX_LEN = 7;
  localparam logic [2:0]  PM_LAST    = 3'(PREFIX_LEN - 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Characters of the "file://" scheme
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h66;  // f
      3'd1:    ch = 8'h69;  // i
      3'd2:    ch = 8'h6C;  // l
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h3A;  // :
      3'd5:    ch = 8'h2F;  // /
      3'd6:    ch = 8'h2F;  // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Hex digit value 0..15, or 16 when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

[rtl/uld_front.sv]
// ----------------------------------------------------------------------------
// uld_front
// Line front end: holds one input word, tracks the carriage return and the
// "file://" prefix, and issues one symbol per cycle to the queue while it has room.
// ----------------------------------------------------------------------------
module uld_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  uld_pkg::in_item_t in_item,
  output logic             push,
  output uld_pkg::sym_t    push_sym,
  input  logic             q_full
);
  import uld_pkg::*;

  logic       cur_v_r, cur_v_nxt;
  in_item_t   cur_r, cur_nxt;
  logic [2:0] pm_r, pm_nxt;
  logic       als_r, als_nxt;
  logic       hr_r, hr_nxt;
  logic [2:0] ri_r, ri_nxt;
  logic       done;
  logic       is_eol;
  logic       consumed;
  logic [7:0] c;

  // Work through the held word one symbol at a time
  always_comb begin
    pm_nxt   = pm_r;
    als_nxt  = als_r;
    hr_nxt   = hr_r;
    ri_nxt   = ri_r;
    push     = 1'b0;
    push_sym = '{eol: 1'b0, data: scheme_char(ri_r)};
    done     = 1'b0;
    consumed = 1'b0;
    is_eol   = cur_r.is_end || (cur_r.text_byte == CH_NEWLINE);
    c        = hr_r ? CH_RETURN : cur_r.text_byte;
    if (cur_v_r) begin
      if (is_eol) begin
        // Replay a partial prefix, then close the line
        if (als_r && (ri_r < pm_r)) begin
          if (!q_full) begin
            push   = 1'b1;
            ri_nxt = 3'(ri_r + 3'd1);
          end
        end else if (!q_full) begin
          push     = 1'b1;
          push_sym = '{eol: 1'b1, data: 8'h00};
          done     = 1'b1;
          pm_nxt   = 3'd0;
          als_nxt  = 1'b1;
          hr_nxt   = 1'b0;
          ri_nxt   = 3'd0;
        end
      end else if (!hr_r && (cur_r.text_byte == CH_RETURN)) begin
        // Hold a carriage return until the next byte shows the line goes on
        hr_nxt = 1'b1;
        done   = 1'b1;
      end else begin
        if (als_r && (pm_r <= PM_LAST) && (c == scheme_char(pm_r))) begin
          pm_nxt   = 3'(pm_r + 3'd1);
          als_nxt  = (pm_r != PM_LAST);
          consumed = 1'b1;
        end else if (als_r && (ri_r < pm_r)) begin
          if (!q_full) begin
            push   = 1'b1;
            ri_nxt = 3'(ri_r + 3'd1);
          end
        end else if (!q_full) begin
          push     = 1'b1;
          push_sym = '{eol: 1'b0, data: c};
          als_nxt  = 1'b0;
          ri_nxt   = 3'd0;
          consumed = 1'b1;
        end
        if (consumed) begin
          if (hr_r) begin
            // Held return went out; a further return is held in its place
            hr_nxt = (cur_r.text_byte == CH_RETURN);
            done   = (cur_r.text_byte == CH_RETURN);
          end else begin
            done = 1'b1;
          end
        end
      end
    end
  end

  // Take a new word once the held one is finished
  assign in_stall = cur_v_r && !done;

  always_comb begin
    cur_v_nxt = cur_v_r;
    cur_nxt   = cur_r;
    if (in_valid && !in_stall) begin
      cur_v_nxt = 1'b1;
      cur_nxt   = in_item;
    end else if (done) begin
      cur_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      pm_r    <= 3'd0;
      als_r   <= 1'b1;
      hr_r    <= 1'b0;
      ri_r    <= 3'd0;
    end else begin
      cur_v_r <= cur_v_nxt;
      pm_r    <= pm_nxt;
      als_r   <= als_nxt;
      hr_r    <= hr_nxt;
      ri_r    <= ri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[rtl/uld_fifo.sv]
// ----------------------------------------------------------------------------
// uld_fifo
// Short symbol queue between the line front end and the escape decoder.
// ----------------------------------------------------------------------------
module uld_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uld_pkg::sym_t push_sym,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output uld_pkg::sym_t head_sym
);
  import uld_pkg::*;

  localparam logic [FIFO_AW:0] FULL_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

  sym_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_sym  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (FIFO_AW + 1)'(cnt_r + 1'b1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = (FIFO_AW + 1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_sym;
    end
  end

endmodule

[rtl/uld_back.sv]
// ----------------------------------------------------------------------------
// uld_back
// Escape decoder: turns percent escapes into bytes, holds back one byte to
// find the end of a path, and drives the output register.
// ----------------------------------------------------------------------------
module uld_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sym_valid,
  input  uld_pkg::sym_t      sym,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output uld_pkg::out_item_t out_item
);
  import uld_pkg::*;

  pct_phase_t ph_r, ph_nxt;
  logic [7:0] first_r, first_nxt;
  logic       pv_r, pv_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r, out_nxt;

  logic       e_req, fin_req, consume, go, out_free, load;
  logic [7:0] e_val;
  logic [4:0] hv, hv1;
  pct_phase_t ph_step;
  logic [7:0] first_step;

  // Decide the one step taken on the head symbol
  always_comb begin
    e_req      = 1'b0;
    e_val      = sym.data;
    fin_req    = 1'b0;
    consume    = 1'b0;
    ph_step    = ph_r;
    first_step = first_r;
    hv         = hex_value(sym.data);
    hv1        = hex_value(first_r);
    unique case (ph_r)
      PCT_ONE: begin
        if (!sym.eol && !hv[4]) begin
          first_step = sym.data;
          ph_step    = PCT_TWO;
          consume    = 1'b1;
        end else begin
          e_req   = 1'b1;
          e_val   = CH_PERCENT;
          ph_step = PCT_IDLE;
        end
      end
      PCT_TWO: begin
        if (!sym.eol && !hv[4]) begin
          e_req   = 1'b1;
          e_val   = {hv1[3:0], hv[3:0]};
          ph_step = PCT_IDLE;
          consume = 1'b1;
        end else begin
          e_req   = 1'b1;
          e_val   = CH_PERCENT;
          ph_step = PCT_FIRST;
        end
      end
      PCT_FIRST: begin
        // Second half of a broken escape: send the held digit
        e_req   = 1'b1;
        e_val   = first_r;
        ph_step = PCT_IDLE;
      end
      default: begin
        if (sym.eol) begin
          fin_req = 1'b1;
          consume = 1'b1;
        end else if (sym.data == CH_PERCENT) begin
          ph_step = PCT_ONE;
          consume = 1'b1;
        end else begin
          e_req   = 1'b1;
          consume = 1'b1;
        end
      end
    endcase
  end

  // Step only when a result it produces has room
  assign out_free = !out_v_r || !out_stall;
  assign go       = sym_valid && (!pv_r || !(e_req || fin_req) || out_free);
  assign pop      = go && consume;
  assign load     = go && pv_r && (e_req || fin_req);

  always_comb begin
    ph_nxt    = ph_r;
    first_nxt = first_r;
    pv_nxt    = pv_r;
    pb_nxt    = pb_r;
    if (go) begin
      ph_nxt    = ph_step;
      first_nxt = first_step;
      if (e_req) begin
        pv_nxt = 1'b1;
        pb_nxt = e_val;
      end else if (fin_req) begin
        pv_nxt = 1'b0;
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (load) begin
      out_v_nxt = 1'b1;
      out_nxt   = '{path_byte: pb_r, path_last: fin_req};
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PCT_IDLE;
      pv_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      pv_r    <= pv_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    pb_r    <= pb_nxt;
    out_r   <= out_nxt;
  end

endmodule

[rtl/uri_list_percent_decoder.sv]
// ----------------------------------------------------------------------------
// uri_list_percent_decoder
// Decodes a URI list byte stream into paths, one decoded byte per word.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and gives one path byte per cycle while no
// stall holds the flow. A word is registered in the line front end, waits
// in a four-entry symbol queue and is held back as a pending byte in the
// escape decoder before it is loaded into the output register. The front
// end issues one symbol a cycle while the queue has room: a carriage return
// followed by more of its line, and each matched byte that a line starting
// like "file://" but breaking off replays, is a symbol of its own that holds
// the input. The escape decoder gives at most one result a cycle: a malformed
// escape sends each byte back out as a step of its own. Each path ends with
// path_last set on its final byte; lines that decode to nothing give no words.
module uri_list_percent_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uld_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output uld_pkg::out_item_t out_item
);
  import uld_pkg::*;

  logic push, q_full, pop, q_not_empty;
  sym_t push_sym, head_sym;

  // Classify bytes into line symbols
  uld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_sym (push_sym),
    .q_full   (q_full)
  );

  // Decouple front and back
  uld_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_sym  (push_sym),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_sym  (head_sym)
  );

  // Decode escapes and mark path ends
  uld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (q_not_empty),
    .sym       (head_sym),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/uld_check.sv]
// ----------------------------------------------------------------------------
// uld_check
// Port-level checks for the URI list percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module uld_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input uld_pkg::out_item_t out_item
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result word changed or dropped");

  // Drop any result on reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Leave reset ready for a word
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind uri_list_percent_decoder uld_check u_check (.*);
